### src/ipp_pkg.sv
// Shared types, codes and format tables for the integer pixel readback packer.
package ipp_pkg;

	// Lane and register geometry.
	localparam int NumLanes = 4;
	localparam int ChanWidth = 32;
	localparam int CfgIdxWidth = 2;
	localparam int CfgDataWidth = 5;

	// Configuration register indexes.
	localparam logic [CfgIdxWidth-1:0] CfgFormat = 2'd0;
	localparam logic [CfgIdxWidth-1:0] CfgType = 2'd1;
	localparam logic [CfgIdxWidth-1:0] CfgSigned = 2'd2;

	// Client format codes.
	localparam logic [3:0] FmtRed = 4'd0;
	localparam logic [3:0] FmtGreen = 4'd1;
	localparam logic [3:0] FmtBlue = 4'd2;
	localparam logic [3:0] FmtAlpha = 4'd3;
	localparam logic [3:0] FmtRg = 4'd4;
	localparam logic [3:0] FmtRgb = 4'd5;
	localparam logic [3:0] FmtBgr = 4'd6;
	localparam logic [3:0] FmtRgba = 4'd7;
	localparam logic [3:0] FmtBgra = 4'd8;

	// Client type codes.
	localparam logic [4:0] TypeUbyte = 5'd0;
	localparam logic [4:0] TypeByte = 5'd1;
	localparam logic [4:0] TypeUshort = 5'd2;
	localparam logic [4:0] TypeShort = 5'd3;
	localparam logic [4:0] TypeUint = 5'd4;
	localparam logic [4:0] TypeInt = 5'd5;
	localparam logic [4:0] TypePackedFirst = 5'd6;
	localparam logic [4:0] TypeLast = 5'd17;

	// Packed layout indexes (type code minus the first packed code).
	localparam logic [3:0] Pk332 = 4'd0;
	localparam logic [3:0] Pk233Rev = 4'd1;
	localparam logic [3:0] Pk565 = 4'd2;
	localparam logic [3:0] Pk565Rev = 4'd3;
	localparam logic [3:0] Pk4444 = 4'd4;
	localparam logic [3:0] Pk4444Rev = 4'd5;
	localparam logic [3:0] Pk5551 = 4'd6;
	localparam logic [3:0] Pk1555Rev = 4'd7;
	localparam logic [3:0] Pk8888 = 4'd8;
	localparam logic [3:0] Pk8888Rev = 4'd9;
	localparam logic [3:0] Pk1010102 = 4'd10;
	localparam logic [3:0] Pk2101010Rev = 4'd11;

	// Clamp limits of the unpacked types, as 33-bit signed values.
	localparam logic signed [32:0] ZeroLim = 33'sd0;
	localparam logic signed [32:0] UbyteHi = 33'sd255;
	localparam logic signed [32:0] ByteLo = -33'sd128;
	localparam logic signed [32:0] ByteHi = 33'sd127;
	localparam logic signed [32:0] UshortHi = 33'sd65535;
	localparam logic signed [32:0] ShortLo = -33'sd32768;
	localparam logic signed [32:0] ShortHi = 33'sd32767;
	localparam logic signed [32:0] UintHi = 33'sd4294967295;
	localparam logic signed [32:0] IntLo = -33'sd2147483648;
	localparam logic signed [32:0] IntHi = 33'sd2147483647;

	// Per-lane control: source select, clamp window, pattern mask and packing shift.
	typedef struct packed {
		logic              en;
		logic [1:0]        sel;
		logic signed [32:0] lo;
		logic signed [32:0] hi;
		logic [31:0]       mask;
		logic [4:0]        shift;
	} lane_ctl_t;

	// Whole-pixel control decoded from the configuration registers.
	typedef struct packed {
		lane_ctl_t [NumLanes-1:0] lane;
		logic                     packed_mode;
		logic [4:0]               bytes;
	} pix_ctl_t;

	// Number of components of a client format.
	function automatic logic [2:0] fmt_count(input logic [3:0] fmt);
		logic [2:0] r;
		case (fmt)
			FmtRed, FmtGreen, FmtBlue, FmtAlpha: r = 3'd1;
			FmtRg: r = 3'd2;
			FmtRgb, FmtBgr: r = 3'd3;
			FmtRgba, FmtBgra: r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// Source channel feeding component c of a client format.
	function automatic logic [1:0] fmt_src(input logic [3:0] fmt, input logic [1:0] c);
		logic [1:0] r;
		r = c;
		case (fmt)
			FmtRed: r = 2'd0;
			FmtGreen: r = 2'd1;
			FmtBlue: r = 2'd2;
			FmtAlpha: r = 2'd3;
			FmtBgr, FmtBgra: begin
				case (c)
					2'd0: r = 2'd2;
					2'd2: r = 2'd0;
					default: r = c;
				endcase
			end
			default: r = c;
		endcase
		return r;
	endfunction

	// Bytes of one unpacked component.
	function automatic logic [4:0] plain_size(input logic [4:0] typ);
		logic [4:0] r;
		case (typ)
			TypeUbyte, TypeByte: r = 5'd1;
			TypeUshort, TypeShort: r = 5'd2;
			default: r = 5'd4;
		endcase
		return r;
	endfunction

	// Field count of a packed layout.
	function automatic logic [2:0] pack_fields(input logic [3:0] p);
		logic [2:0] r;
		case (p)
			Pk332, Pk233Rev, Pk565, Pk565Rev: r = 3'd3;
			default: r = 3'd4;
		endcase
		return r;
	endfunction

	// Bytes of one packed word.
	function automatic logic [4:0] pack_bytes(input logic [3:0] p);
		logic [4:0] r;
		case (p)
			Pk332, Pk233Rev: r = 5'd1;
			Pk8888, Pk8888Rev, Pk1010102, Pk2101010Rev: r = 5'd4;
			default: r = 5'd2;
		endcase
		return r;
	endfunction

	// Field width of component c in a packed layout.
	function automatic logic [3:0] pack_width(input logic [3:0] p, input logic [1:0] c);
		logic [3:0] r;
		case (p)
			Pk332, Pk233Rev: r = (c == 2'd2) ? 4'd2 : 4'd3;
			Pk565, Pk565Rev: r = (c == 2'd1) ? 4'd6 : 4'd5;
			Pk4444, Pk4444Rev: r = 4'd4;
			Pk5551, Pk1555Rev: r = (c == 2'd3) ? 4'd1 : 4'd5;
			Pk8888, Pk8888Rev: r = 4'd8;
			Pk1010102, Pk2101010Rev: r = (c == 2'd3) ? 4'd2 : 4'd10;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	// Bit position of component c in a packed layout.
	function automatic logic [4:0] pack_shift(input logic [3:0] p, input logic [1:0] c);
		logic [4:0] r;
		r = 5'd0;
		case (p)
			Pk332: begin
				case (c)
					2'd0: r = 5'd5;
					2'd1: r = 5'd2;
					default: r = 5'd0;
				endcase
			end
			Pk233Rev: begin
				case (c)
					2'd1: r = 5'd3;
					2'd2: r = 5'd6;
					default: r = 5'd0;
				endcase
			end
			Pk565: begin
				case (c)
					2'd0: r = 5'd11;
					2'd1: r = 5'd5;
					default: r = 5'd0;
				endcase
			end
			Pk565Rev: begin
				case (c)
					2'd1: r = 5'd5;
					2'd2: r = 5'd11;
					default: r = 5'd0;
				endcase
			end
			Pk4444: r = 5'(4'd12 - {c, 2'b00});
			Pk4444Rev: r = 5'({c, 2'b00});
			Pk5551: begin
				case (c)
					2'd0: r = 5'd11;
					2'd1: r = 5'd6;
					2'd2: r = 5'd1;
					default: r = 5'd0;
				endcase
			end
			Pk1555Rev: begin
				case (c)
					2'd1: r = 5'd5;
					2'd2: r = 5'd10;
					2'd3: r = 5'd15;
					default: r = 5'd0;
				endcase
			end
			Pk8888: r = 5'd24 - {c, 3'b000};
			Pk8888Rev: r = {c, 3'b000};
			Pk1010102: begin
				case (c)
					2'd0: r = 5'd22;
					2'd1: r = 5'd12;
					2'd2: r = 5'd2;
					default: r = 5'd0;
				endcase
			end
			Pk2101010Rev: begin
				case (c)
					2'd1: r = 5'd10;
					2'd2: r = 5'd20;
					2'd3: r = 5'd30;
					default: r = 5'd0;
				endcase
			end
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Decode format and type into lane controls; an unsupported pairing leaves all lanes off.
	function automatic pix_ctl_t decode_ctl(input logic [3:0] fmt, input logic [4:0] typ);
		pix_ctl_t   r;
		logic [2:0] cnt;
		logic [3:0] pidx;
		logic [3:0] w;
		r = '0;
		cnt = fmt_count(fmt);
		pidx = 4'(typ - TypePackedFirst);
		if (fmt <= FmtBgra && typ <= TypeLast) begin
			if (typ >= TypePackedFirst) begin
				if (pack_fields(pidx) == cnt) begin
					r.packed_mode = 1'b1;
					r.bytes = pack_bytes(pidx);
					for (int c = 0; c < NumLanes; c++) begin
						w = pack_width(pidx, 2'(c));
						r.lane[c].sel = fmt_src(fmt, 2'(c));
						r.lane[c].en = (3'(c) < cnt);
						r.lane[c].lo = ZeroLim;
						r.lane[c].hi = (33'sd1 <<< w) - 33'sd1;
						r.lane[c].mask = '1;
						r.lane[c].shift = pack_shift(pidx, 2'(c));
					end
				end
			end else begin
				r.bytes = 5'(cnt) * plain_size(typ);
				for (int c = 0; c < NumLanes; c++) begin
					r.lane[c].sel = fmt_src(fmt, 2'(c));
					r.lane[c].en = (3'(c) < cnt);
					case (typ)
						TypeUbyte: begin
							r.lane[c].lo = ZeroLim;
							r.lane[c].hi = UbyteHi;
							r.lane[c].mask = 32'h0000_00FF;
						end
						TypeByte: begin
							r.lane[c].lo = ByteLo;
							r.lane[c].hi = ByteHi;
							r.lane[c].mask = 32'h0000_00FF;
						end
						TypeUshort: begin
							r.lane[c].lo = ZeroLim;
							r.lane[c].hi = UshortHi;
							r.lane[c].mask = 32'h0000_FFFF;
						end
						TypeShort: begin
							r.lane[c].lo = ShortLo;
							r.lane[c].hi = ShortHi;
							r.lane[c].mask = 32'h0000_FFFF;
						end
						TypeUint: begin
							r.lane[c].lo = ZeroLim;
							r.lane[c].hi = UintHi;
							r.lane[c].mask = '1;
						end
						default: begin
							r.lane[c].lo = IntLo;
							r.lane[c].hi = IntHi;
							r.lane[c].mask = '1;
						end
					endcase
				end
			end
		end
		return r;
	endfunction

endpackage

### src/ipp_lane.sv
// One component lane: selects a source channel, widens it, clamps it and registers the pattern.
module ipp_lane (
	input  logic                                   clk,
	input  logic                                   adv,
	input  logic [ipp_pkg::NumLanes-1:0][31:0]     chans,
	input  logic                                   src_signed,
	input  ipp_pkg::lane_ctl_t                     ctl,
	output logic [31:0]                            comp_s1
);
	import ipp_pkg::*;

	logic [31:0]        raw;
	logic signed [32:0] wide;
	logic signed [32:0] clamped;

	// Pick the source channel and read it as signed or unsigned.
	assign raw = chans[ctl.sel];
	assign wide = signed'({src_signed & raw[31], raw});

	// Clamp to the window of the destination type or field.
	always_comb begin
		if (wide < ctl.lo) begin
			clamped = ctl.lo;
		end else if (wide > ctl.hi) begin
			clamped = ctl.hi;
		end else begin
			clamped = wide;
		end
	end

	// Stage register holding the masked component pattern.
	always_ff @(posedge clk) begin
		if (adv) begin
			comp_s1 <= clamped[31:0] & ctl.mask;
		end
	end

endmodule

### src/ipp_merge.sv
// Merge stage: combines the lane results into separate components or one packed word.
module ipp_merge (
	input  logic                               clk,
	input  logic                               adv,
	input  logic [ipp_pkg::NumLanes-1:0][31:0] lane_comp,
	input  ipp_pkg::pix_ctl_t                  ctl,
	input  logic                               row_end_s1,
	output logic [ipp_pkg::NumLanes-1:0][31:0] comp_s2,
	output logic [4:0]                         bytes_s2,
	output logic                               row_end_s2
);
	import ipp_pkg::*;

	logic [NumLanes-1:0][31:0] comp_d;
	logic [31:0]               word;

	// Shift every enabled lane into place and OR them into one word.
	always_comb begin
		word = '0;
		for (int c = 0; c < NumLanes; c++) begin
			if (ctl.lane[c].en) begin
				word = word | (lane_comp[c] << ctl.lane[c].shift);
			end
		end
	end

	// Packed types put the word in the first component; unpacked types pass enabled lanes.
	always_comb begin
		comp_d = '0;
		if (ctl.packed_mode) begin
			comp_d[0] = word;
		end else begin
			for (int c = 0; c < NumLanes; c++) begin
				comp_d[c] = ctl.lane[c].en ? lane_comp[c] : 32'd0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			comp_s2 <= comp_d;
			bytes_s2 <= ctl.bytes;
			row_end_s2 <= row_end_s1;
		end
	end

endmodule

### src/integer_pixel_readback_packer_core.sv
// Top level of the integer pixel readback packer: configuration, lanes, merge and flow control.
// A request passes the registered lanes, then the registered merge stage, which drives the outputs.
// Throughput: one pixel per cycle unless the output stalls; four clamp lanes feed the merge stage.
// Stall from the output holds both stages; a free output register lets the pipeline move on.
// Reset (arst_n low, asynchronous) empties both stages and sets format rgba, type ubyte, unsigned.
module integer_pixel_readback_packer_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [ipp_pkg::CfgIdxWidth-1:0]       cfg_index,
	input  logic [ipp_pkg::CfgDataWidth-1:0]      cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [31:0]                           chan_r,
	input  logic [31:0]                           chan_g,
	input  logic [31:0]                           chan_b,
	input  logic [31:0]                           chan_a,
	input  logic                                  row_end_in,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [31:0]                           comp_zero,
	output logic [31:0]                           comp_one,
	output logic [31:0]                           comp_two,
	output logic [31:0]                           comp_three,
	output logic [4:0]                            pixel_bytes,
	output logic                                  row_end_out
);
	import ipp_pkg::*;

	logic [3:0]                format_q;
	logic [4:0]                type_q;
	logic                      signed_q;
	pix_ctl_t                  ctl;
	logic [NumLanes-1:0][31:0] chans;
	logic [NumLanes-1:0][31:0] lane_comp_s1;
	logic [NumLanes-1:0][31:0] comp_s2;
	logic                      valid_s1;
	logic                      valid_s2;
	logic                      row_end_s1;
	logic                      adv_s1;
	logic                      adv_s2;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FmtRgba;
			type_q <= TypeUbyte;
			signed_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CfgFormat: format_q <= cfg_data[3:0];
				CfgType: type_q <= cfg_data[4:0];
				CfgSigned: signed_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Format and type decode; the user keeps them stable while requests are in flight, not enforced.
	assign ctl = decode_ctl(format_q, type_q);

	// Flow control: each stage moves when the one after it is empty or moving.
	assign adv_s2 = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;
	assign adv_s1 = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Row end marker travels beside the lanes.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			row_end_s1 <= row_end_in;
		end
	end

	assign chans = {chan_a, chan_b, chan_g, chan_r};

	// Four clamp lanes working side by side.
	for (genvar g = 0; g < NumLanes; g++) begin : g_lane
		ipp_lane u_lane (
			.clk        (clk),
			.adv        (adv_s1),
			.chans      (chans),
			.src_signed (signed_q),
			.ctl        (ctl.lane[g]),
			.comp_s1    (lane_comp_s1[g])
		);
	end

	ipp_merge u_merge (
		.clk        (clk),
		.adv        (adv_s2),
		.lane_comp  (lane_comp_s1),
		.ctl        (ctl),
		.row_end_s1 (row_end_s1),
		.comp_s2    (comp_s2),
		.bytes_s2   (pixel_bytes),
		.row_end_s2 (row_end_out)
	);

	assign out_valid = valid_s2;
	assign comp_zero = comp_s2[0];
	assign comp_one = comp_s2[1];
	assign comp_two = comp_s2[2];
	assign comp_three = comp_s2[3];

endmodule

### src/ipp_checker.sv
// Port-level checker for the integer pixel readback packer, bound to the top level.
module ipp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] comp_zero,
	input logic [31:0] comp_one,
	input logic [31:0] comp_two,
	input logic [31:0] comp_three,
	input logic [4:0]  pixel_bytes
);

	// A stalled result holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(comp_zero) && $stable(pixel_bytes))
		else $error("stalled result changed");

	// An accepted request is on the output once it has passed both stages.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("accepted request did not reach the output");

	// The byte count is one a supported pairing can give.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_bytes == 5'd0 || pixel_bytes == 5'd1 || pixel_bytes == 5'd2 ||
			pixel_bytes == 5'd3 || pixel_bytes == 5'd4 || pixel_bytes == 5'd6 ||
			pixel_bytes == 5'd8 || pixel_bytes == 5'd12 || pixel_bytes == 5'd16))
		else $error("impossible pixel byte count");

	// An unsupported pairing gives all-zero components.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_bytes == 5'd0 |->
			comp_zero == 32'd0 && comp_one == 32'd0 && comp_two == 32'd0 && comp_three == 32'd0)
		else $error("unsupported pairing gave non-zero components");

endmodule

bind integer_pixel_readback_packer_core ipp_checker u_ipp_checker (.*);
